// ===== hw/rtl/bst_pkg.sv =====
// Shared types and codes for the bounded set table.
package bst_pkg;

	// Field widths of the request and response beats.
	localparam int COMMAND_W = 2;
	localparam int VALUE_W   = 32;
	localparam int INDEX_W   = 4;
	localparam int OUTCOME_W = 2;
	localparam int COUNT_W   = 5;

	// Widest element the table supports; used to zero-extend and truncate values.
	localparam int WIDE_W = 64;

	// Largest count the capacity register can ever allow.
	localparam int CAP_MAX = (1 << COUNT_W) - 1;

	// Capacity register value after reset.
	localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

	// Command codes.
	localparam logic [COMMAND_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [COMMAND_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [COMMAND_W-1:0] CMD_MEMBER = 2'd2;
	localparam logic [COMMAND_W-1:0] CMD_READ   = 2'd3;

	// Outcome codes.
	localparam logic [OUTCOME_W-1:0] OUT_DONE    = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_PRESENT = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_FULL    = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_ABSENT  = 2'd3;

	// Request beat.
	typedef struct packed {
		logic [COMMAND_W-1:0] command;
		logic [VALUE_W-1:0]   value;
		logic [INDEX_W-1:0]   index;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [COUNT_W-1:0]   element_count;
		logic [VALUE_W-1:0]   read_value;
	} rsp_t;

	// Update strobes broadcast to every cell.
	typedef struct packed {
		logic append;
		logic remove;
	} ctl_t;

endpackage

// ===== hw/rtl/bounded_set_table.sv =====
// Bounded set table: a row of compare-and-shift cells holding distinct values.
//
// The req channel carries one command per beat: add, remove, member query or
// read by index. Every accepted req beat produces exactly one rsp beat with
// the outcome, the element count after the command and, for a read, the entry.
// All cells compare the value in parallel and a removal shifts the later
// entries down one place in the same cycle, and each rsp beat is valid in the
// cycle after acceptance.
// Throughput is one beat per cycle without stalls; the response register sets
// that figure, and req_ready is high whenever that register is empty or being
// drained. When the receiver stalls, the rsp beat holds and req_ready stays low.
// The capacity register is to be written through cfg_we/cfg_wdata only while idle;
// the block does not enforce this. Values above the cell count act as that count.
// Reset empties the set, clears the rsp valid flag and sets the capacity to 16.
// Entry storage has no reset; only positions below the count are ever read.
module bounded_set_table import bst_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	// Cells beyond the largest reachable count would never be used.
	localparam int CELLS = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;

	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    cap_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  req_fire;
	logic [WIDE_W-1:0]     value_wide;
	logic [ELEM_WIDTH-1:0] elem;
	logic [COUNT_W-1:0]    cap_eff;
	logic                  found;
	logic                  has_room;
	logic                  index_ok;
	ctl_t                  ctl;
	rsp_t                  rsp_d;
	logic [COUNT_W-1:0]    count_d;
	logic [ELEM_WIDTH-1:0] rd_elem;
	logic [WIDE_W-1:0]     rd_wide;

	logic [ELEM_WIDTH-1:0] entries   [CELLS];
	logic [CELLS-1:0]      match;
	logic                  shift_out [CELLS];
	logic                  rd_sel    [CELLS];

	// Handshake: accept whenever the response register can take a new beat.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Fit the incoming value to the element width.
	assign value_wide = {{(WIDE_W - VALUE_W){1'b0}}, req.value};
	assign elem       = value_wide[ELEM_WIDTH-1:0];

	// Effective capacity never exceeds the number of cells.
	assign cap_eff  = (cap_q > COUNT_W'(CELLS)) ? COUNT_W'(CELLS) : cap_q;
	assign has_room = count_q < cap_eff;
	assign index_ok = {1'b0, req.index} < count_q;

	// The shift flag out of the last cell is the OR of all matches.
	assign found = shift_out[CELLS-1];

	// Row of cells, each handing its entry to the left neighbor on removal.
	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		logic [ELEM_WIDTH-1:0] next_entry;
		logic                  shift_in;

		if (j == CELLS - 1) begin : g_last
			assign next_entry = entries[j];
		end else begin : g_mid
			assign next_entry = entries[j+1];
		end

		if (j == 0) begin : g_first
			assign shift_in = 1'b0;
		end else begin : g_rest
			assign shift_in = shift_out[j-1];
		end

		assign rd_sel[j] = ({1'b0, req.index} == COUNT_W'(j)) && (COUNT_W'(j) < count_q);

		bst_cell #(
			.ELEM_WIDTH(ELEM_WIDTH),
			.POS       (j)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.elem      (elem),
			.next_entry(next_entry),
			.shift_in  (shift_in),
			.entry     (entries[j]),
			.match     (match[j]),
			.shift_out (shift_out[j])
		);
	end

	// Read port: OR together the one selected entry.
	always_comb begin
		rd_elem = '0;
		for (int j = 0; j < CELLS; j++) begin
			if (rd_sel[j]) begin
				rd_elem = rd_elem | entries[j];
			end
		end
		rd_wide                   = '0;
		rd_wide[ELEM_WIDTH-1:0]   = rd_elem;
	end

	// Command decode: outcome, next count and cell update strobes.
	always_comb begin
		rsp_d      = '0;
		count_d    = count_q;
		ctl.append = 1'b0;
		ctl.remove = 1'b0;
		unique case (req.command)
			CMD_ADD: begin
				if (found) begin
					rsp_d.outcome = OUT_PRESENT;
				end else if (!has_room) begin
					rsp_d.outcome = OUT_FULL;
				end else begin
					rsp_d.outcome = OUT_DONE;
					count_d       = count_q + COUNT_W'(1);
					ctl.append    = req_fire;
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					rsp_d.outcome = OUT_DONE;
					count_d       = count_q - COUNT_W'(1);
					ctl.remove    = req_fire;
				end else begin
					rsp_d.outcome = OUT_ABSENT;
				end
			end
			CMD_MEMBER: begin
				rsp_d.outcome = found ? OUT_DONE : OUT_ABSENT;
			end
			CMD_READ: begin
				if (index_ok) begin
					rsp_d.outcome    = OUT_DONE;
					rsp_d.read_value = rd_wide[VALUE_W-1:0];
				end else begin
					rsp_d.outcome = OUT_ABSENT;
				end
			end
			default: begin
				rsp_d.outcome = OUT_ABSENT;
			end
		endcase
		rsp_d.element_count = count_d;
	end

	// Control state: count, capacity and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (req_fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_d;
		end
	end

	// The count never exceeds the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CELLS))
		else $error("element count beyond cell count");

	// Stored values are distinct, so at most one cell matches.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one cell matches");

	// A successful add raises the count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.command == CMD_ADD && rsp_d.outcome == OUT_DONE)
		|=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("add did not raise the count");

	// A successful remove lowers the count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.command == CMD_REMOVE && rsp_d.outcome == OUT_DONE)
		|=> count_q == $past(count_q) - COUNT_W'(1))
		else $error("remove did not lower the count");

	// The response beat reports the count the table holds afterward.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> rsp_q.element_count == count_q)
		else $error("reported count differs from stored count");

endmodule

// ===== hw/rtl/bst_cell.sv =====
// One storage cell of the set table: holds an entry, compares it, shifts on removal.
module bst_cell import bst_pkg::*; #(
	parameter int ELEM_WIDTH = 32,
	parameter int POS        = 0
) (
	input  logic                  clk,
	input  ctl_t                  ctl,
	input  logic [COUNT_W-1:0]    count,
	input  logic [ELEM_WIDTH-1:0] elem,
	input  logic [ELEM_WIDTH-1:0] next_entry,
	input  logic                  shift_in,
	output logic [ELEM_WIDTH-1:0] entry,
	output logic                  match,
	output logic                  shift_out
);

	logic [ELEM_WIDTH-1:0] entry_q;
	logic                  occupied;
	logic                  is_tail;

	// The cell holds a live entry only while its position is below the count.
	assign occupied = COUNT_W'(POS) < count;
	assign is_tail  = COUNT_W'(POS) == count;

	// Compare against the broadcast value; the shift flag ripples down the row.
	assign match     = occupied && (entry_q == elem);
	assign shift_out = shift_in | match;
	assign entry     = entry_q;

	// Append lands in the first free cell; removal pulls from the right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.append && is_tail) begin
			entry_q <= elem;
		end else if (ctl.remove && shift_out) begin
			entry_q <= next_entry;
		end
	end

endmodule
